@@ rtl/core/srgbx_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srgbx_pkg
// Shared constants and elaboration-time builders for the sRGB curve tables.
// ----------------------------------------------------------------------------
package srgbx_pkg;

	localparam int BIG_W = 512;
	localparam int TBL_DEPTH = 256;
	localparam int CHAN_W = 8;
	localparam int NUM_CHAN = 3;
	localparam int SCALE_W = 24;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 24'h010000;

	// rational form of the curve constants: (x + 0.055)/1.055 with x = k/255
	localparam logic [63:0] CURVE_DEN = 64'd269025;
	localparam logic [63:0] LIN_DEN = 64'd32946;

	typedef logic [BIG_W-1:0] big_t;
	typedef logic [63:0] tbl_t [TBL_DEPTH];

	function automatic big_t pow12(logic [63:0] x);
		big_t b;
		big_t s;
		big_t q;
		b = BIG_W'(x);
		s = b * b;
		q = s * s;
		q = q * s;
		return q * q;
	endfunction

	function automatic big_t pow5(logic [63:0] x);
		big_t b;
		big_t s;
		b = BIG_W'(x);
		s = b * b;
		s = s * s;
		return s * b;
	endfunction

	// shift-subtract quotient, only evaluated while building the tables
	function automatic logic [63:0] udiv(logic [63:0] n, logic [63:0] d);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], n[i]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// linear light per code, lf fraction bits, round half up
	function automatic tbl_t build_decode(int lf);
		tbl_t t;
		big_t den12;
		big_t rhs;
		big_t p;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		logic [63:0] num;
		den12 = pow12(CURVE_DEN);
		for (int k = 0; k < TBL_DEPTH; k++) begin
			if (k <= 10) begin
				num = (64'(k) * 64'd20) << lf;
				t[k] = udiv(num + LIN_DEN, 64'd2 * LIN_DEN);
			end else begin
				lo = 64'd0;
				hi = 64'd1 << lf;
				rhs = pow12(64'd1000 * 64'(k) + 64'd14025) << (5 * lf + 5);
				for (int it = 0; it < 64; it++) begin
					if (lo < hi) begin
						mid = lo + ((hi - lo + 64'd1) >> 1);
						p = pow5(64'd2 * mid - 64'd1) * den12;
						if (p <= rhs) begin
							lo = mid;
						end else begin
							hi = mid - 64'd1;
						end
					end
				end
				t[k] = lo;
			end
		end
		return t;
	endfunction

	// smallest product value that encodes to code j or above, pf fraction bits
	function automatic tbl_t build_encode(int pf);
		tbl_t t;
		big_t den12;
		big_t rhs;
		big_t p;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		logic [63:0] num;
		den12 = pow12(CURVE_DEN);
		t[0] = 64'd0;
		for (int j = 1; j < TBL_DEPTH; j++) begin
			if (j <= 10) begin
				num = ((64'd2 * 64'(j) - 64'd1) * 64'd5) << pf;
				t[j] = udiv(num + LIN_DEN - 64'd1, LIN_DEN);
			end else begin
				lo = 64'd0;
				hi = 64'd1 << pf;
				rhs = pow12(64'd1000 * 64'(j) + 64'd13525) << (5 * pf);
				for (int it = 0; it < 64; it++) begin
					if (lo < hi) begin
						mid = lo + ((hi - lo) >> 1);
						p = pow5(mid) * den12;
						if (p >= rhs) begin
							hi = mid;
						end else begin
							lo = mid + 64'd1;
						end
					end
				end
				t[j] = lo;
			end
		end
		return t;
	endfunction

endpackage

@@ rtl/core/srgbx_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srgbx_decode
// One channel: sRGB code to linear light via ROM, times the exposure scale.
// ----------------------------------------------------------------------------
module srgbx_decode
	import srgbx_pkg::*;
#(
	parameter int LINEAR_FRAC_BITS = 16
) (
	input  logic [CHAN_W-1:0]                          code,
	input  logic [SCALE_W-1:0]                         scale,
	output logic [LINEAR_FRAC_BITS+1+SCALE_W-1:0]      prod
);

	localparam int LIN_W = LINEAR_FRAC_BITS + 1;
	localparam int PROD_W = LIN_W + SCALE_W;
	localparam tbl_t DEC_ROM = build_decode(LINEAR_FRAC_BITS);

	logic [LIN_W-1:0] lin;

	assign lin = DEC_ROM[code][LIN_W-1:0];
	assign prod = PROD_W'(lin) * PROD_W'(scale);

endmodule

@@ rtl/core/srgbx_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srgbx_search
// Four steps of the binary search over the encode thresholds.
// ----------------------------------------------------------------------------
module srgbx_search
	import srgbx_pkg::*;
#(
	parameter int LINEAR_FRAC_BITS = 16,
	parameter int SCALE_FRAC_BITS = 16,
	parameter int TOP_BIT = 7
) (
	input  logic [LINEAR_FRAC_BITS+1+SCALE_W-1:0] prod,
	input  logic [CHAN_W-1:0]                     code_in,
	output logic [CHAN_W-1:0]                     code_out
);

	localparam int STEPS = 4;
	localparam tbl_t ENC_THR = build_encode(LINEAR_FRAC_BITS + SCALE_FRAC_BITS);

	logic [CHAN_W-1:0] code;
	logic [CHAN_W-1:0] cand;
	logic [63:0]       prod_x;

	// thresholds are nondecreasing: code is the largest index with threshold <= prod
	always_comb begin
		prod_x = 64'(prod);
		code = code_in;
		cand = code_in;
		for (int b = TOP_BIT; b > TOP_BIT - STEPS; b--) begin
			cand = code | (CHAN_W'(1) << b);
			if (prod_x >= ENC_THR[cand]) begin
				code = cand;
			end
		end
		code_out = code;
	end

endmodule

@@ rtl/core/srgb_exposure_correction.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srgb_exposure_correction
// Pipeline: a result beat passes the input reg, the decode/multiply reg and
//   two search regs of four steps each before it is valid at the output.
// Throughput: one pixel per clock; each stage holds only while the next is full.
// Reset: arst_n clears all valid flags and loads exposure scale 1.0 (0x010000).
// ----------------------------------------------------------------------------
module srgb_exposure_correction
	import srgbx_pkg::*;
#(
	parameter int SCALE_FRAC_BITS = 16,
	parameter int LINEAR_FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [23:0] cfg_wr_data,     // exposure_scale
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,    // red_in, green_in, blue_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata     // red_out, green_out, blue_out
);

	localparam int PROD_W = LINEAR_FRAC_BITS + 1 + SCALE_W;

	logic [SCALE_W-1:0] scale_q;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	logic [NUM_CHAN-1:0][CHAN_W-1:0] px_s1;
	logic [NUM_CHAN-1:0][PROD_W-1:0] prod_d;
	logic [NUM_CHAN-1:0][PROD_W-1:0] prod_s2;
	logic [NUM_CHAN-1:0][PROD_W-1:0] prod_s3;
	logic [NUM_CHAN-1:0][CHAN_W-1:0] hi_d;
	logic [NUM_CHAN-1:0][CHAN_W-1:0] hi_s3;
	logic [NUM_CHAN-1:0][CHAN_W-1:0] res_d;
	logic [NUM_CHAN-1:0][CHAN_W-1:0] res_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (cfg_wr_en) begin
			scale_q <= cfg_wr_data;
		end
	end

	// per-stage ready lets bubbles collapse
	assign rdy_s4 = !v_s4 || m_axis_tready;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign s_axis_tready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= s_axis_tvalid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_axis_tvalid) begin
			px_s1 <= s_axis_tdata;
		end
		if (rdy_s2 && v_s1) begin
			prod_s2 <= prod_d;
		end
		if (rdy_s3 && v_s2) begin
			prod_s3 <= prod_s2;
			hi_s3 <= hi_d;
		end
		if (rdy_s4 && v_s3) begin
			res_s4 <= res_d;
		end
	end

	for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
		srgbx_decode #(
			.LINEAR_FRAC_BITS(LINEAR_FRAC_BITS)
		) u_decode (
			.code (px_s1[c]),
			.scale(scale_q),
			.prod (prod_d[c])
		);

		srgbx_search #(
			.LINEAR_FRAC_BITS(LINEAR_FRAC_BITS),
			.SCALE_FRAC_BITS (SCALE_FRAC_BITS),
			.TOP_BIT         (7)
		) u_search_hi (
			.prod    (prod_s2[c]),
			.code_in ('0),
			.code_out(hi_d[c])
		);

		srgbx_search #(
			.LINEAR_FRAC_BITS(LINEAR_FRAC_BITS),
			.SCALE_FRAC_BITS (SCALE_FRAC_BITS),
			.TOP_BIT         (3)
		) u_search_lo (
			.prod    (prod_s3[c]),
			.code_in (hi_s3[c]),
			.code_out(res_d[c])
		);
	end

	assign m_axis_tvalid = v_s4;
	assign m_axis_tdata = res_s4;

endmodule

@@ dv/tb_srgb_exposure_correction.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_srgb_exposure_correction
// Self-checking bench for the sRGB exposure correction pipe. Builds its own
// decode levels and encode thresholds with exact wide-integer checks, predicts
// output pixels from the current exposure scale, and compares beats in
// order under random source gaps and sink stalls, across several scales.
// ----------------------------------------------------------------------------
module tb_srgb_exposure_correction;

	localparam int LIN_FRAC = 16;
	localparam int PROD_FRAC = 32;
	localparam longint unsigned GAMMA_DEN = 64'd269025;
	localparam longint unsigned SLOPE_DEN = 64'd32946;
	localparam int RANDOM_PIXELS = 800;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD = 300;

	typedef logic [447:0] wide_t;

	typedef struct packed {
		logic        set_scale;
		logic [23:0] scale;
		logic [23:0] pix;      // red [7:0], green [15:8], blue [23:16]
		logic        typed;
		logic [23:0] want;
	} stim_row_t;

	// typed-in results only for trivially known cases
	localparam stim_row_t DIRECTED [22] = '{
		'{1'b0, 24'h000000, 24'h000000, 1'b1, 24'h000000},
		'{1'b0, 24'h000000, 24'hFFFFFF, 1'b1, 24'hFFFFFF},
		'{1'b0, 24'h000000, 24'hFF8000, 1'b0, 24'h000000},
		'{1'b0, 24'h000000, 24'h0B0A01, 1'b0, 24'h000000},
		'{1'b0, 24'h000000, 24'h64FE0C, 1'b0, 24'h000000},
		'{1'b1, 24'h000000, 24'h000000, 1'b0, 24'h000000},
		'{1'b0, 24'h000000, 24'hFFFFFF, 1'b1, 24'h000000},
		'{1'b0, 24'h000000, 24'hFE8001, 1'b1, 24'h000000},
		'{1'b1, 24'hFFFFFF, 24'h000000, 1'b0, 24'h000000},
		'{1'b0, 24'h000000, 24'hFFFFFF, 1'b1, 24'hFFFFFF},
		'{1'b0, 24'h000000, 24'h000000, 1'b1, 24'h000000},
		'{1'b0, 24'h000000, 24'h0A0201, 1'b0, 24'h000000},
		'{1'b0, 24'h000000, 24'hFE800B, 1'b0, 24'h000000},
		'{1'b1, 24'h000001, 24'h000000, 1'b0, 24'h000000},
		'{1'b0, 24'h000000, 24'hFFFFFF, 1'b0, 24'h000000},
		'{1'b0, 24'h000000, 24'h03C880, 1'b0, 24'h000000},
		'{1'b1, 24'h008000, 24'h000000, 1'b0, 24'h000000},
		'{1'b0, 24'h000000, 24'h4080FF, 1'b0, 24'h000000},
		'{1'b0, 24'h000000, 24'hFF55AA, 1'b0, 24'h000000},
		'{1'b1, 24'h010000, 24'h000000, 1'b0, 24'h000000},
		'{1'b0, 24'h000000, 24'h7F7F7F, 1'b0, 24'h000000},
		'{1'b0, 24'h000000, 24'h0A3FC0, 1'b0, 24'h000000}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [23:0] cfg_wr_data = 24'h0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = 24'h0;   // red_in, green_in, blue_in
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;           // red_out, green_out, blue_out

	longint unsigned linear_level [256];
	longint unsigned code_threshold [256];
	logic [23:0]     exposure = 24'h010000;
	logic [23:0]     pending_px [$];
	int              errors = 0;
	int              cycle_count = 0;
	bit              hold_request = 1'b0;

	srgb_exposure_correction dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic wide_t ipow(longint unsigned x, int n);
		wide_t acc;
		wide_t base;
		acc = 1;
		base = x;
		for (int i = 0; i < n; i++) acc = acc * base;
		return acc;
	endfunction

	// Real-valued guess, then nudged until the exact integer inequality holds.
	task automatic build_curves();
		wide_t den12;
		wide_t lim;
		real lv;
		longint unsigned v;
		den12 = ipow(GAMMA_DEN, 12);
		for (int k = 0; k < 256; k++) begin
			if (k <= 10) begin
				v = longint'(k) * 20;
				linear_level[k] = ((v << LIN_FRAC) + SLOPE_DEN) / (2 * SLOPE_DEN);
			end else begin
				// round half up: largest L with (2L-1)^5 den^12 <= num^12 2^(5F+5)
				lim = ipow(64'd1000 * k + 64'd14025, 12) << (5 * LIN_FRAC + 5);
				lv = ((k / 255.0 + 0.055) / 1.055) ** 2.4;
				v = longint'($floor(lv * 65536.0 + 0.5));
				while (ipow(2 * v + 1, 5) * den12 <= lim) v++;
				while (ipow(2 * v - 1, 5) * den12 > lim) v--;
				linear_level[k] = v;
			end
		end
		code_threshold[0] = 0;
		for (int j = 1; j < 256; j++) begin
			if (j <= 10) begin
				v = longint'(2 * j - 1) * 5;
				code_threshold[j] = ((v << PROD_FRAC) + SLOPE_DEN - 1) / SLOPE_DEN;
			end else begin
				// smallest Y with Y^5 den^12 >= num^12 2^(5G)
				lim = ipow(64'd1000 * j + 64'd13525, 12) << (5 * PROD_FRAC);
				lv = ((((j - 0.5) / 255.0) + 0.055) / 1.055) ** 2.4;
				v = longint'($ceil(lv * 4294967296.0));
				while (v > 0 && ipow(v - 1, 5) * den12 >= lim) v--;
				while (ipow(v, 5) * den12 < lim) v++;
				code_threshold[j] = v;
			end
		end
	endtask

	function automatic logic [7:0] corrected_code(logic [7:0] code, logic [23:0] scale);
		longint unsigned y;
		int n;
		y = linear_level[code] * longint'(scale);
		n = 0;
		for (int j = 1; j < 256; j++) begin
			if (y >= code_threshold[j]) n++;
		end
		return n[7:0];
	endfunction

	function automatic logic [23:0] corrected_pixel(logic [23:0] pix, logic [23:0] scale);
		return {corrected_code(pix[23:16], scale), corrected_code(pix[15:8], scale),
			corrected_code(pix[7:0], scale)};
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] pick_code();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return 8'($urandom_range(0, 255));
		case (r % 6)
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd10;
			3: return 8'd11;
			4: return 8'd254;
			default: return 8'd255;
		endcase
	endfunction

	// called at a falling edge; returns at a falling edge with tvalid left high
	task automatic push_pixel(input logic [23:0] pix, input logic typed,
		input logic [23:0] want, input int gap);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= pix;
		do @(posedge clk); while (!s_axis_tready);
		pending_px.insert(pending_px.size(), typed ? want : corrected_pixel(pix, exposure));
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_px.size() != 0) @(negedge clk);
	endtask

	task automatic write_scale(input logic [23:0] scale);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= scale;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		exposure = scale;
	endtask

	task automatic check_byte(input string chan, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, chan, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : result_check
		logic [23:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_px.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, got %h", $time,
					m_axis_tdata);
				errors++;
			end else begin
				want = pending_px.pop_front();
				check_byte("red", want[7:0], m_axis_tdata[7:0]);
				check_byte("green", want[15:8], m_axis_tdata[15:8]);
				check_byte("blue", want[23:16], m_axis_tdata[23:16]);
			end
		end
	end

	initial begin : sink_pacing
		int hold_left;
		int calm_left;
		int r;
		hold_left = 0;
		calm_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = LONG_HOLD;
			end
			r = $urandom_range(0, 99);
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (calm_left > 0) begin
				calm_left--;
				m_axis_tready <= 1'b1;
			end else if (r < 2) begin
				calm_left = $urandom_range(50, 200);
				m_axis_tready <= 1'b1;
			end else if (r < 70) begin
				m_axis_tready <= 1'b1;
			end else begin
				hold_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
				m_axis_tready <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : stimulus
		int sent;
		int phase;
		int n;
		int r;
		bit no_gaps;
		logic [23:0] scale;
		build_curves();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].set_scale)
				write_scale(DIRECTED[i].scale);
			else
				push_pixel(DIRECTED[i].pix, DIRECTED[i].typed, DIRECTED[i].want, pick_gap());
		end

		sent = 0;
		phase = 0;
		while (sent < RANDOM_PIXELS) begin
			r = $urandom_range(0, 3);
			case (phase)
				0: scale = 24'hFFFFFF;
				1: scale = 24'h000000;
				2: scale = 24'h010000;
				3: scale = 24'h000001;
				default: begin
					if (r == 0) scale = 24'($urandom_range(0, 24'hFFFFFF));
					else if (r == 1) scale = 24'($urandom_range(24'h004000, 24'h040000));
					else if (r == 2) scale = 24'($urandom_range(0, 24'h002000));
					else scale = 24'($urandom_range(24'h040000, 24'hFFFFFF));
				end
			endcase
			write_scale(scale);
			n = $urandom_range(60, 120);
			no_gaps = ($urandom_range(0, 3) == 0);
			// back up the pipe: sink held off while the source keeps offering
			if (phase == 2) begin
				hold_request = 1'b1;
				no_gaps = 1'b1;
			end
			repeat (n) begin
				push_pixel({pick_code(), pick_code(), pick_code()}, 1'b0, 24'h0,
					no_gaps ? 0 : pick_gap());
			end
			sent += n;
			phase++;
		end

		drain();
		repeat (10) @(posedge clk);
		if (errors == 0 && pending_px.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ srgb_exposure_correction.f @@
rtl/core/srgbx_pkg.sv
rtl/core/srgbx_decode.sv
rtl/core/srgbx_search.sv
rtl/core/srgb_exposure_correction.sv
dv/tb_srgb_exposure_correction.sv
